[hw/rtl/obagg_pkg.sv]
package obagg_pkg;

   localparam int SIDE_W   = 1;
   localparam int PRICE_W  = 17;
   localparam int VOLUME_W = 16;
   localparam int TOTAL_W  = 32;
   localparam int DEPTH_W  = 6;
   localparam int BOUND_W  = PRICE_W + 1;

   localparam logic [DEPTH_W-1:0] DEPTH_CAP   = 6'd32;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 6'd32;

   localparam logic SIDE_BUY  = 1'b0;
   localparam logic SIDE_SELL = 1'b1;

   localparam logic REG_REPORT_DEPTH = 1'b0;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   typedef struct packed {
      logic [SIDE_W-1:0]   side;
      logic [PRICE_W-1:0]  price;
      logic [VOLUME_W-1:0] volume;
      logic                last_order;
   } order_type;

   typedef struct packed {
      logic       valid;
      order_type  order;
   } queue_head_type;

   typedef struct packed {
      logic [PRICE_W-1:0] price;
      logic [TOTAL_W-1:0] volume;
   } entry_type;

   typedef struct packed {
      logic [SIDE_W-1:0]  out_side;
      logic [PRICE_W-1:0] out_price;
      logic [TOTAL_W-1:0] out_volume;
      logic               overflow_seen;
      logic               last_line;
   } line_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ADD_SCAN,
      ST_ADD_WRITE,
      ST_RPT_START,
      ST_SELL_FIND,
      ST_SELL_EMIT,
      ST_SELL_OUT,
      ST_BUY_EMIT,
      ST_BUY_OUT,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/obagg_if.sv]
interface obagg_req_if;
   import obagg_pkg::*;
   logic                valid;
   logic                ready;
   logic [SIDE_W-1:0]   side;
   logic [PRICE_W-1:0]  price;
   logic [VOLUME_W-1:0] volume;
   logic                last_order;

   modport source (output valid, side, price, volume, last_order, input ready);
   modport sink   (input valid, side, price, volume, last_order, output ready);
endinterface

interface obagg_rsp_if;
   import obagg_pkg::*;
   logic               valid;
   logic               ready;
   logic [SIDE_W-1:0]  out_side;
   logic [PRICE_W-1:0] out_price;
   logic [TOTAL_W-1:0] out_volume;
   logic               overflow_seen;
   logic               last_line;

   modport source (output valid, out_side, out_price, out_volume, overflow_seen, last_line,
                   input ready);
   modport sink   (input valid, out_side, out_price, out_volume, overflow_seen, last_line,
                   output ready);
endinterface

[hw/rtl/obagg_front.sv]
module obagg_front import obagg_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   obagg_req_if.sink      req,
   output queue_head_type head,
   input  logic           pop
);

   order_type             buf_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]     cnt_ff, cnt_in;
   logic                  push;
   logic                  do_pop;
   order_type             req_order;

   assign req.ready  = (cnt_ff != QCNT_W'(QUEUE_DEPTH));
   assign push       = req.valid && req.ready;
   assign do_pop     = pop && (cnt_ff != '0);
   assign head.valid = (cnt_ff != '0);
   assign head.order = buf_ff[rd_ptr_ff];

   always_comb begin
      req_order.side       = req.side;
      req_order.price      = req.price;
      req_order.volume     = req.volume;
      req_order.last_order = req.last_order;
      wr_ptr_in = push ? QPTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? QPTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = QCNT_W'(cnt_ff + 1'b1);
      end else if (do_pop && !push) begin
         cnt_in = QCNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         buf_ff[wr_ptr_ff] <= req_order;
      end
   end

endmodule

[hw/rtl/obagg_engine.sv]
module obagg_engine import obagg_pkg::*; #(
   parameter int MAX_LEVELS = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  queue_head_type     head,
   output logic               pop,
   input  logic [DEPTH_W-1:0] report_depth,
   obagg_rsp_if.source        rsp
);

   localparam int CW = $clog2(MAX_LEVELS + 1);
   localparam int IW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int MW = (CW > DEPTH_W) ? CW : DEPTH_W;
   localparam int AW = IW + 1;

   entry_type            mem [2**AW];

   state_type            state_ff, state_in;
   order_type            ord_ff, ord_in;
   logic [CW-1:0]        buy_cnt_ff, buy_cnt_in;
   logic [CW-1:0]        sell_cnt_ff, sell_cnt_in;
   logic                 dropped_ff, dropped_in;
   logic [CW-1:0]        issue_ff, issue_in;
   logic                 rd_vld_ff, rd_vld_in;
   logic [IW-1:0]        rd_idx_ff, rd_idx_in;
   entry_type            rdata_ff;
   logic                 have_ff, have_in;
   logic [PRICE_W-1:0]   best_price_ff, best_price_in;
   logic [TOTAL_W-1:0]   best_vol_ff, best_vol_in;
   logic [IW-1:0]        best_idx_ff, best_idx_in;
   logic [BOUND_W-1:0]   bound_ff, bound_in;
   logic [DEPTH_W-1:0]   pass_ff, pass_in;
   logic [DEPTH_W-1:0]   ks_ff, ks_in;
   logic [DEPTH_W-1:0]   kb_ff, kb_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   line_type             line_ff, line_in;

   logic                 scanning;
   logic                 scan_side;
   logic [CW-1:0]        scan_cnt;
   logic                 scan_done;
   logic                 cand;
   logic [AW-1:0]        raddr;
   logic                 wr_en;
   logic [AW-1:0]        waddr;
   entry_type            wdata;
   logic [TOTAL_W:0]     sum;
   logic [MW-1:0]        depth_eff;
   logic [MW-1:0]        sell_ext;
   logic [MW-1:0]        buy_ext;
   logic [DEPTH_W-1:0]   ks_new;
   logic [DEPTH_W-1:0]   kb_new;
   logic [DEPTH_W-1:0]   pass_next;
   logic                 slot_free;

   assign rsp.valid         = rsp_vld_ff;
   assign rsp.out_side      = line_ff.out_side;
   assign rsp.out_price     = line_ff.out_price;
   assign rsp.out_volume    = line_ff.out_volume;
   assign rsp.overflow_seen = line_ff.overflow_seen;
   assign rsp.last_line     = line_ff.last_line;

   assign slot_free = !rsp_vld_ff || rsp.ready;
   assign pass_next = DEPTH_W'(pass_ff + 1'b1);

   always_comb begin
      scanning  = (state_ff inside {ST_ADD_SCAN, ST_SELL_FIND, ST_SELL_EMIT, ST_BUY_EMIT});
      scan_side = (state_ff inside {ST_ADD_SCAN, ST_ADD_WRITE}) ? ord_ff.side :
                  ((state_ff inside {ST_SELL_FIND, ST_SELL_EMIT}) ? SIDE_SELL : SIDE_BUY);
      scan_cnt  = scan_side ? sell_cnt_ff : buy_cnt_ff;
      scan_done = (issue_ff == scan_cnt) && !rd_vld_ff;
      raddr     = {scan_side, issue_ff[IW-1:0]};

      depth_eff = (report_depth > DEPTH_CAP) ? MW'(DEPTH_CAP) : MW'(report_depth);
      sell_ext  = MW'(sell_cnt_ff);
      buy_ext   = MW'(buy_cnt_ff);
      ks_new    = (sell_ext < depth_eff) ? DEPTH_W'(sell_ext) : DEPTH_W'(depth_eff);
      kb_new    = (buy_ext < depth_eff) ? DEPTH_W'(buy_ext) : DEPTH_W'(depth_eff);

      sum = {1'b0, best_vol_ff} + (TOTAL_W + 1)'(ord_ff.volume);

      case (state_ff)
         ST_ADD_SCAN:  cand = (rdata_ff.price == ord_ff.price);
         ST_SELL_FIND: cand = ({1'b0, rdata_ff.price} >= bound_ff) &&
                              (!have_ff || rdata_ff.price < best_price_ff);
         ST_SELL_EMIT,
         ST_BUY_EMIT:  cand = ({1'b0, rdata_ff.price} < bound_ff) &&
                              (!have_ff || rdata_ff.price > best_price_ff);
         default:      cand = 1'b0;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      ord_in        = ord_ff;
      buy_cnt_in    = buy_cnt_ff;
      sell_cnt_in   = sell_cnt_ff;
      dropped_in    = dropped_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      have_in       = have_ff;
      best_price_in = best_price_ff;
      best_vol_in   = best_vol_ff;
      best_idx_in   = best_idx_ff;
      bound_in      = bound_ff;
      pass_in       = pass_ff;
      ks_in         = ks_ff;
      kb_in         = kb_ff;
      rsp_vld_in    = rsp_vld_ff && !rsp.ready;
      line_in       = line_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      waddr         = {ord_ff.side, best_idx_ff};
      wdata.price   = ord_ff.price;
      wdata.volume  = TOTAL_W'(ord_ff.volume);

      if (scanning && issue_ff != scan_cnt) begin
         issue_in  = CW'(issue_ff + 1'b1);
         rd_vld_in = 1'b1;
         rd_idx_in = issue_ff[IW-1:0];
      end
      if (rd_vld_ff && cand) begin
         have_in       = 1'b1;
         best_price_in = rdata_ff.price;
         best_vol_in   = rdata_ff.volume;
         best_idx_in   = rd_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               ord_in   = head.order;
               issue_in = '0;
               have_in  = 1'b0;
               state_in = ST_ADD_SCAN;
            end
         end
         ST_ADD_SCAN: begin
            if (scan_done) begin
               state_in = ST_ADD_WRITE;
            end
         end
         ST_ADD_WRITE: begin
            if (have_ff) begin
               wr_en        = 1'b1;
               wdata.volume = sum[TOTAL_W] ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
            end else if (scan_cnt != CW'(MAX_LEVELS)) begin
               wr_en = 1'b1;
               waddr = {ord_ff.side, scan_cnt[IW-1:0]};
               if (ord_ff.side == SIDE_SELL) begin
                  sell_cnt_in = CW'(sell_cnt_ff + 1'b1);
               end else begin
                  buy_cnt_in = CW'(buy_cnt_ff + 1'b1);
               end
            end else begin
               dropped_in = 1'b1;
            end
            state_in = ord_ff.last_order ? ST_RPT_START : ST_IDLE;
         end
         ST_RPT_START: begin
            ks_in    = ks_new;
            kb_in    = kb_new;
            pass_in  = '0;
            issue_in = '0;
            have_in  = 1'b0;
            if (ks_new != '0) begin
               bound_in = '0;
               state_in = ST_SELL_FIND;
            end else if (kb_new != '0) begin
               bound_in = BOUND_W'(1) << PRICE_W;
               state_in = ST_BUY_EMIT;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SELL_FIND: begin
            if (scan_done) begin
               bound_in = BOUND_W'(best_price_ff) + 1'b1;
               issue_in = '0;
               have_in  = 1'b0;
               if (pass_next == ks_ff) begin
                  pass_in  = '0;
                  state_in = ST_SELL_EMIT;
               end else begin
                  pass_in = pass_next;
               end
            end
         end
         ST_SELL_EMIT: begin
            if (scan_done) begin
               state_in = ST_SELL_OUT;
            end
         end
         ST_SELL_OUT: begin
            if (slot_free) begin
               rsp_vld_in            = 1'b1;
               line_in.out_side      = SIDE_SELL;
               line_in.out_price     = best_price_ff;
               line_in.out_volume    = best_vol_ff;
               line_in.overflow_seen = dropped_ff;
               line_in.last_line     = (pass_next == ks_ff) && (kb_ff == '0);
               issue_in              = '0;
               have_in               = 1'b0;
               bound_in              = BOUND_W'(best_price_ff);
               pass_in               = pass_next;
               state_in              = ST_SELL_EMIT;
               if (pass_next == ks_ff) begin
                  pass_in = '0;
                  if (kb_ff != '0) begin
                     bound_in = BOUND_W'(1) << PRICE_W;
                     state_in = ST_BUY_EMIT;
                  end else begin
                     state_in = ST_DONE;
                  end
               end
            end
         end
         ST_BUY_EMIT: begin
            if (scan_done) begin
               state_in = ST_BUY_OUT;
            end
         end
         ST_BUY_OUT: begin
            if (slot_free) begin
               rsp_vld_in            = 1'b1;
               line_in.out_side      = SIDE_BUY;
               line_in.out_price     = best_price_ff;
               line_in.out_volume    = best_vol_ff;
               line_in.overflow_seen = dropped_ff;
               line_in.last_line     = (pass_next == kb_ff);
               issue_in              = '0;
               have_in               = 1'b0;
               bound_in              = BOUND_W'(best_price_ff);
               pass_in               = pass_next;
               state_in              = (pass_next == kb_ff) ? ST_DONE : ST_BUY_EMIT;
            end
         end
         ST_DONE: begin
            buy_cnt_in  = '0;
            sell_cnt_in = '0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         buy_cnt_ff  <= '0;
         sell_cnt_ff <= '0;
         dropped_ff  <= 1'b0;
         issue_ff    <= '0;
         rd_vld_ff   <= 1'b0;
         have_ff     <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         buy_cnt_ff  <= buy_cnt_in;
         sell_cnt_ff <= sell_cnt_in;
         dropped_ff  <= dropped_in;
         issue_ff    <= issue_in;
         rd_vld_ff   <= rd_vld_in;
         have_ff     <= have_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      ord_ff        <= ord_in;
      rd_idx_ff     <= rd_idx_in;
      best_price_ff <= best_price_in;
      best_vol_ff   <= best_vol_in;
      best_idx_ff   <= best_idx_in;
      bound_ff      <= bound_in;
      pass_ff       <= pass_in;
      ks_ff         <= ks_in;
      kb_ff         <= kb_in;
      line_ff       <= line_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

endmodule

[hw/rtl/order_book_aggregate_top_depth.sv]
// channel   | dir | handshake          | payload
// req_ch    | in  | valid/ready        | side, price, volume, last_order
// rsp_ch    | out | valid/ready        | out_side, out_price, out_volume, overflow_seen, last_line
// csr (APB) | in  | psel/penable/pready| paddr, pwdata, prdata (report_depth)
//
// An order's price is matched against the table of its side one entry per cycle
// through the single read port of the level memory. A report takes (2*Ks + Kb)
// scans of the side tables, Ks and Kb being the reported sell and buy line counts.
// Synchronous reset clears counts, flag and handshakes; no memory clear pass.
// Orders queue up to four deep during a scan or a report; a stalled response
// holds the engine until it is taken.
module order_book_aggregate_top_depth import obagg_pkg::*; #(
   parameter int MAX_LEVELS = 64
) (
   input  logic                clock,
   input  logic                reset,
   obagg_req_if.sink           req_ch,
   obagg_rsp_if.source         rsp_ch,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [2:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   logic [DEPTH_W-1:0] depth_ff, depth_in;
   logic               reg_hit;
   queue_head_type     head;
   logic               pop;

   assign pready  = 1'b1;
   assign reg_hit = (paddr[2] == REG_REPORT_DEPTH) && (paddr[1:0] == 2'b00);
   assign prdata  = reg_hit ? 32'(depth_ff) : 32'd0;

   always_comb begin
      depth_in = depth_ff;
      if (psel && penable && pwrite && reg_hit) begin
         depth_in = pwdata[DEPTH_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else begin
         depth_ff <= depth_in;
      end
   end

   obagg_front u_front (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .head  (head),
      .pop   (pop)
   );

   obagg_engine #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_engine (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .pop          (pop),
      .report_depth (depth_ff),
      .rsp          (rsp_ch)
   );

endmodule

[hw/rtl/obagg_checker.sv]
module obagg_checker import obagg_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [SIDE_W-1:0]  out_side,
   input logic [PRICE_W-1:0] out_price,
   input logic [TOTAL_W-1:0] out_volume,
   input logic               overflow_seen,
   input logic               last_line
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_price) && $stable(out_volume))
      else $error("response changed while stalled");

   a_flag_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && overflow_seen |=> !rsp_valid || overflow_seen)
      else $error("overflow flag dropped without reset");

   a_buy_after_sell: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && (out_side == SIDE_BUY) && !last_line
      |=> !rsp_valid || (out_side == SIDE_BUY))
      else $error("sell line after buy line in one report");

endmodule

bind order_book_aggregate_top_depth obagg_checker u_obagg_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .out_side      (rsp_ch.out_side),
   .out_price     (rsp_ch.out_price),
   .out_volume    (rsp_ch.out_volume),
   .overflow_seen (rsp_ch.overflow_seen),
   .last_line     (rsp_ch.last_line)
);

[test/order_book_aggregate_top_depth_tb.sv]
`timescale 1ns / 1ps

module order_book_aggregate_top_depth_tb;
   import obagg_pkg::*;

   localparam int LEVELS = 64;

   typedef struct {
      order_type o;
      bit        typed;
      line_type  e;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   obagg_req_if req_if ();
   obagg_rsp_if rsp_if ();

   order_book_aggregate_top_depth #(.MAX_LEVELS(LEVELS)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if.sink),
      .rsp_ch  (rsp_if.source),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // book model
   logic [PRICE_W-1:0] buy_px[LEVELS];
   logic [TOTAL_W-1:0] buy_vol[LEVELS];
   int                 buy_cnt;
   logic [PRICE_W-1:0] sell_px[LEVELS];
   logic [TOTAL_W-1:0] sell_vol[LEVELS];
   int                 sell_cnt;
   logic               dropped;
   logic [DEPTH_W-1:0] depth_cfg;

   line_type     pending_lines[$];
   stim_row_type rows[$];
   int           errors;
   bit           quiet;
   bit           long_hold;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #200ms;
      $display("Simulation FAILED");
      $finish;
   end

   function automatic line_type mk_line(logic s, logic [PRICE_W-1:0] p, logic [TOTAL_W-1:0] v,
                                        logic ov, logic ll);
      line_type l;
      l.out_side = s;
      l.out_price = p;
      l.out_volume = v;
      l.overflow_seen = ov;
      l.last_line = ll;
      return l;
   endfunction

   function automatic order_type mk_order(logic s, logic [PRICE_W-1:0] p,
                                          logic [VOLUME_W-1:0] v, logic last);
      order_type o;
      o.side = s;
      o.price = p;
      o.volume = v;
      o.last_order = last;
      return o;
   endfunction

   task automatic add_row(order_type o, bit typed = 0, line_type e = '0);
      stim_row_type r;
      r.o = o;
      r.typed = typed;
      r.e = e;
      rows = {rows, r};
   endtask

   task automatic book_add(ref logic [PRICE_W-1:0] px[LEVELS], ref logic [TOTAL_W-1:0] vol[LEVELS],
                           ref int cnt, input logic [PRICE_W-1:0] p, input logic [VOLUME_W-1:0] v);
      logic [TOTAL_W:0] sum;
      for (int i = 0; i < cnt; i++) begin
         if (px[i] == p) begin
            sum = {1'b0, vol[i]} + (TOTAL_W + 1)'(v);
            vol[i] = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
            return;
         end
      end
      if (cnt >= LEVELS) begin
         dropped = 1'b1;
         return;
      end
      px[cnt] = p;
      vol[cnt] = TOTAL_W'(v);
      cnt++;
   endtask

   task automatic book_sort(ref logic [PRICE_W-1:0] px[LEVELS], ref logic [TOTAL_W-1:0] vol[LEVELS],
                            input int cnt, input bit up);
      logic [PRICE_W-1:0] p;
      logic [TOTAL_W-1:0] v;
      int                 j;
      for (int i = 1; i < cnt; i++) begin
         p = px[i];
         v = vol[i];
         j = i;
         while (j > 0 && (up ? px[j-1] > p : px[j-1] < p)) begin
            px[j] = px[j-1];
            vol[j] = vol[j-1];
            j--;
         end
         px[j] = p;
         vol[j] = v;
      end
   endtask

   task automatic predict_book(order_type o, output line_type lines[$]);
      int d;
      int k;
      lines = {};
      if (o.side == SIDE_SELL) book_add(sell_px, sell_vol, sell_cnt, o.price, o.volume);
      else book_add(buy_px, buy_vol, buy_cnt, o.price, o.volume);
      if (!o.last_order) return;
      d = (depth_cfg > DEPTH_CAP) ? DEPTH_CAP : depth_cfg;
      book_sort(sell_px, sell_vol, sell_cnt, 1);
      k = (sell_cnt < d) ? sell_cnt : d;
      for (int i = k; i > 0; i--)
         lines = {lines, mk_line(SIDE_SELL, sell_px[i-1], sell_vol[i-1], dropped, 1'b0)};
      book_sort(buy_px, buy_vol, buy_cnt, 0);
      k = (buy_cnt < d) ? buy_cnt : d;
      for (int i = 0; i < k; i++)
         lines = {lines, mk_line(SIDE_BUY, buy_px[i], buy_vol[i], dropped, 1'b0)};
      if (lines.size() > 0) lines[lines.size()-1].last_line = 1'b1;
      buy_cnt = 0;
      sell_cnt = 0;
   endtask

   // called at a falling edge; returns at a falling edge with valid still high
   task automatic send_order(order_type o, bit typed = 0, line_type e = '0);
      line_type lines[$];
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_if.valid = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.side = o.side;
      req_if.price = o.price;
      req_if.volume = o.volume;
      req_if.last_order = o.last_order;
      do @(posedge clock); while (!req_if.ready);
      predict_book(o, lines);
      if (typed) pending_lines = {pending_lines, e};
      else pending_lines = {pending_lines, lines};
      @(negedge clock);
   endtask

   task automatic drain();
      req_if.valid = 1'b0;
      while (pending_lines.size() > 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic csr_write_depth(logic [31:0] v);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = {REG_REPORT_DEPTH, 2'b00};
      pwdata = v;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      depth_cfg = v[DEPTH_W-1:0];
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      if (prdata[DEPTH_W-1:0] !== depth_cfg) begin
         $error("report_depth readback: expected %0d actual %0d", depth_cfg, prdata[DEPTH_W-1:0]);
         errors++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   task automatic run_rows(int lo, int hi);
      for (int i = lo; i <= hi; i++) send_order(rows[i].o, rows[i].typed, rows[i].e);
   endtask

   function automatic logic [PRICE_W-1:0] rand_price(logic [PRICE_W-1:0] base);
      case ($urandom_range(0, 3))
         0: return PRICE_W'($urandom);
         1: return $urandom_range(0, 1) ? '1 : '0;
         default: return base + PRICE_W'($urandom_range(0, 15));
      endcase
   endfunction

   task automatic random_phase(int n_items);
      int                 sent;
      int                 len;
      logic [PRICE_W-1:0] base;
      logic [VOLUME_W-1:0] v;
      logic               last;
      sent = 0;
      while (sent < n_items) begin
         len = $urandom_range(1, 24);
         base = PRICE_W'($urandom);
         if (sent > n_items / 2 && !quiet && $urandom_range(0, 5) == 0) long_hold = 1'b1;
         for (int i = 0; i < len; i++) begin
            v = ($urandom_range(0, 3) == 0) ? '1 : VOLUME_W'($urandom);
            last = (i == len - 1) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 19) == 0);
            send_order(mk_order(1'($urandom_range(0, 1)), rand_price(base), v, last));
            sent++;
         end
      end
      send_order(mk_order(1'($urandom_range(0, 1)), rand_price(base), VOLUME_W'($urandom), 1'b1));
      drain();
   endtask

   // result side: random ready bursts, one long hold-off on request
   initial begin
      rsp_if.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_if.ready = 1'b0;
            repeat (600) @(negedge clock);
            long_hold = 1'b0;
         end else if (quiet) begin
            rsp_if.ready = 1'b1;
            @(negedge clock);
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_if.ready = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_if.ready = 1'b1;
            repeat ($urandom_range(1, 20)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      line_type exp_l;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_lines.size() == 0) begin
            $error("unexpected report line: price %0d", rsp_if.out_price);
            errors++;
         end else begin
            exp_l = pending_lines.pop_front();
            if (rsp_if.out_side !== exp_l.out_side) begin
               $error("out_side: expected %0d actual %0d", exp_l.out_side, rsp_if.out_side);
               errors++;
            end
            if (rsp_if.out_price !== exp_l.out_price) begin
               $error("out_price: expected %0d actual %0d", exp_l.out_price, rsp_if.out_price);
               errors++;
            end
            if (rsp_if.out_volume !== exp_l.out_volume) begin
               $error("out_volume: expected %0d actual %0d", exp_l.out_volume, rsp_if.out_volume);
               errors++;
            end
            if (rsp_if.overflow_seen !== exp_l.overflow_seen) begin
               $error("overflow_seen: expected %0d actual %0d", exp_l.overflow_seen,
                      rsp_if.overflow_seen);
               errors++;
            end
            if (rsp_if.last_line !== exp_l.last_line) begin
               $error("last_line: expected %0d actual %0d", exp_l.last_line, rsp_if.last_line);
               errors++;
            end
         end
      end
   end

   initial begin
      errors = 0;
      quiet = 1'b0;
      long_hold = 1'b0;
      buy_cnt = 0;
      sell_cnt = 0;
      dropped = 1'b0;
      depth_cfg = DEPTH_RESET;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_if.valid = 1'b0;
      req_if.side = '0;
      req_if.price = '0;
      req_if.volume = '0;
      req_if.last_order = 1'b0;

      // depth 32 after reset
      add_row(mk_order(SIDE_BUY, '0, '0, 1), 1, mk_line(SIDE_BUY, '0, '0, 0, 1));
      add_row(mk_order(SIDE_SELL, '1, '1, 1), 1, mk_line(SIDE_SELL, '1, 32'hFFFF, 0, 1));
      add_row(mk_order(SIDE_BUY, 100, 10, 0));
      add_row(mk_order(SIDE_BUY, 100, 20, 0));
      add_row(mk_order(SIDE_BUY, 200, 5, 0));
      add_row(mk_order(SIDE_SELL, 300, 7, 0));
      add_row(mk_order(SIDE_SELL, 250, 1, 0));
      add_row(mk_order(SIDE_SELL, 300, 3, 1));
      add_row(mk_order(SIDE_SELL, 50, 1, 0));
      add_row(mk_order(SIDE_SELL, 60, 2, 1));
      // depth 1
      add_row(mk_order(SIDE_BUY, 10, 1, 0));
      add_row(mk_order(SIDE_BUY, 30, 2, 0));
      add_row(mk_order(SIDE_BUY, 20, 3, 0));
      add_row(mk_order(SIDE_SELL, 40, 4, 0));
      add_row(mk_order(SIDE_SELL, 35, 5, 1));
      // depth 0: no lines, tables still clear
      add_row(mk_order(SIDE_BUY, 7, 9, 0));
      add_row(mk_order(SIDE_SELL, 8, 9, 1));
      // depth 63 behaves as 32
      add_row(mk_order(SIDE_BUY, 1000, 100, 0));
      add_row(mk_order(SIDE_BUY, 999, 1, 0));
      add_row(mk_order(SIDE_SELL, 1001, 2, 0));
      add_row(mk_order(SIDE_SELL, 131070, 3, 0));
      add_row(mk_order(SIDE_BUY, 1000, 65535, 0));
      add_row(mk_order(SIDE_SELL, 1001, 65535, 1));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      run_rows(0, 9);
      drain();
      csr_write_depth(1);
      run_rows(10, 14);
      drain();
      csr_write_depth(0);
      run_rows(15, 16);
      drain();
      csr_write_depth(63);
      run_rows(17, 22);
      drain();

      // long result stall while orders keep coming
      quiet = 1'b1;
      long_hold = 1'b1;
      for (int i = 0; i < 16; i++)
         send_order(mk_order(SIDE_BUY, PRICE_W'(i + 40), VOLUME_W'(i + 1), 1'b1));
      drain();
      quiet = 1'b0;

      // repeated volume at one price
      csr_write_depth(32);
      for (int i = 0; i < 4; i++) send_order(mk_order(SIDE_BUY, 5, '1, 0));
      send_order(mk_order(SIDE_BUY, 5, '1, 1));
      drain();

      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: csr_write_depth(32);
            1: csr_write_depth(1);
            2: csr_write_depth($urandom_range(2, 31));
            default: csr_write_depth($urandom_range(0, 63) | 32'(($urandom_range(0, 1)) << 5));
         endcase
         random_phase(50);
      end

      // full buy table, then sticky drop flag
      csr_write_depth(32);
      for (int i = 0; i < LEVELS + 3; i++)
         send_order(mk_order(SIDE_BUY, PRICE_W'(i * 3 + 1), VOLUME_W'(i), 0));
      send_order(mk_order(SIDE_SELL, 77, 1, 1));
      drain();

      csr_write_depth(63);
      quiet = 1'b1;
      random_phase(35);

      while (pending_lines.size() > 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
